[design/smf_pkg.sv]
// ============================================================================
// smf_pkg
// Shared types, phase codes and helpers for the MIDI file event parser.
// ============================================================================
package smf_pkg;

    // parse phase codes
    localparam logic [3:0] PH_MAGIC     = 4'd0;
    localparam logic [3:0] PH_HLEN      = 4'd1;
    localparam logic [3:0] PH_HWORDS    = 4'd2;
    localparam logic [3:0] PH_HSKIP     = 4'd3;
    localparam logic [3:0] PH_CHUNK_ID  = 4'd4;
    localparam logic [3:0] PH_CHUNK_LEN = 4'd5;
    localparam logic [3:0] PH_DELTA     = 4'd6;
    localparam logic [3:0] PH_STATUS    = 4'd7;
    localparam logic [3:0] PH_META_TYPE = 4'd8;
    localparam logic [3:0] PH_META_LEN  = 4'd9;
    localparam logic [3:0] PH_SYSEX_LEN = 4'd10;
    localparam logic [3:0] PH_SKIP      = 4'd11;
    localparam logic [3:0] PH_TEMPO     = 4'd12;
    localparam logic [3:0] PH_D1        = 4'd13;
    localparam logic [3:0] PH_D2        = 4'd14;
    localparam logic [3:0] PH_DONE      = 4'd15;

    // result kinds
    localparam logic [1:0] KIND_OFF     = 2'd0;
    localparam logic [1:0] KIND_ON      = 2'd1;
    localparam logic [1:0] KIND_TEMPO   = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_MAGIC = 2'd1;
    localparam logic [1:0] ERR_HLEN  = 2'd2;
    localparam logic [1:0] ERR_TRACK = 2'd3;

    localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
    localparam logic [15:0] DIV_DEFAULT   = 16'd480;
    localparam logic [31:0] SAT_MAX       = 32'hFFFF_FFFF;
    localparam logic [7:0]  META_TEMPO    = 8'h51;
    localparam logic [7:0]  ST_META       = 8'hFF;
    localparam logic [7:0]  ST_SYSEX      = 8'hF0;
    localparam logic [7:0]  ST_SYSEX_CONT = 8'hF7;
    localparam logic [3:0]  TYPE_OFF      = 4'h8;
    localparam logic [3:0]  TYPE_ON       = 4'h9;
    localparam logic [3:0]  TYPE_PROG     = 4'hC;
    localparam logic [3:0]  TYPE_PRESS    = 4'hD;

    localparam int          RQ_DEPTH = 4;
    localparam int          RQ_AW    = 2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] track;
        logic [31:0] tick;
        logic [3:0]  channel;
        logic [7:0]  key;
        logic [7:0]  velocity;
        logic [23:0] tempo_us;
        logic [31:0] note_count;
        logic [15:0] file_format;
        logic [14:0] ticks_per_quarter;
        logic [1:0]  error;
        logic        last_result;
    } t_result;

    // header magic "MThd" and track magic "MTrk"
    function automatic logic [7:0] hdr_magic(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0: v = 8'h4D;
            2'd1: v = 8'h54;
            2'd2: v = 8'h68;
            default: v = 8'h64;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] trk_magic(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0: v = 8'h4D;
            2'd1: v = 8'h54;
            2'd2: v = 8'h72;
            default: v = 8'h6B;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT_MAX : s[31:0];
    endfunction

endpackage

[design/smf_core.sv]
// ============================================================================
// smf_core
// Parser state and the one-pass byte update; yields up to two results per item.
// ============================================================================
module smf_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic [7:0]          i_byte,
    input  logic                i_eof,
    output logic [1:0]          o_cnt,
    output smf_pkg::t_result    o_res0,
    output smf_pkg::t_result    o_res1
);
    import smf_pkg::*;

    logic [3:0]  r_ph, n_ph;
    logic [3:0]  r_fbc, n_fbc;
    logic [31:0] r_hl, n_hl;
    logic [15:0] r_td, n_td;
    logic [15:0] r_ti, n_ti;
    logic [31:0] r_cbl, n_cbl;
    logic [31:0] r_vv, n_vv;
    logic [2:0]  r_vl, n_vl;
    logic [31:0] r_ct, n_ct;
    logic [7:0]  r_rs, n_rs;
    logic [7:0]  r_mk, n_mk;
    logic [31:0] r_sk, n_sk;
    logic [7:0]  r_fd, n_fd;
    logic [23:0] r_tg, n_tg;
    logic [31:0] r_ns, n_ns;
    logic [31:0] r_lt, n_lt;
    logic [23:0] r_st, n_st;
    logic [15:0] r_dv, n_dv;
    logic [15:0] r_fw, n_fw;
    logic [1:0]  r_ec, n_ec;
    logic        r_bad, n_bad;

    // next state and results for one byte
    always_comb begin
        logic [3:0]  idx;
        logic [15:0] dvt;
        logic        ah, ft, vdo, body, pdone;
        logic [7:0]  vd2;
        logic [1:0]  cnt;
        t_result     rv, r0, r1;

        n_ph = r_ph; n_fbc = r_fbc; n_hl = r_hl; n_td = r_td; n_ti = r_ti;
        n_cbl = r_cbl; n_vv = r_vv; n_vl = r_vl; n_ct = r_ct; n_rs = r_rs;
        n_mk = r_mk; n_sk = r_sk; n_fd = r_fd; n_tg = r_tg; n_ns = r_ns;
        n_lt = r_lt; n_st = r_st; n_dv = r_dv; n_fw = r_fw; n_ec = r_ec;
        n_bad = r_bad;
        idx = '0; dvt = '0; ah = 1'b0; ft = 1'b0; vdo = 1'b0; body = 1'b1;
        pdone = 1'b0; vd2 = '0; cnt = '0; rv = '0; r0 = '0; r1 = '0;

        if (n_ph <= PH_HWORDS) begin
            // header magic, length and words
            idx   = n_fbc;
            n_fbc = n_fbc + 4'd1;
            if (n_ph == PH_MAGIC) begin
                if (i_byte != hdr_magic(idx[1:0])) begin
                    n_ec = ERR_MAGIC;
                    n_ph = PH_DONE;
                end else if (idx == 4'd3) begin
                    n_ph = PH_HLEN;
                end
            end else if (n_ph == PH_HLEN) begin
                n_hl = {n_hl[23:0], i_byte};
                if (idx == 4'd7) n_ph = PH_HWORDS;
            end else begin
                if (idx < 4'd10) begin
                    n_fw = {n_fw[7:0], i_byte};
                end else if (idx < 4'd12) begin
                    n_td = {n_td[7:0], i_byte};
                end else if (idx == 4'd12) begin
                    n_dv = {i_byte, 8'h00};
                end else begin
                    dvt = {n_dv[15:8], i_byte};
                    if (dvt == 16'd0 || dvt[15]) dvt = DIV_DEFAULT;
                    n_dv = dvt;
                    if (n_hl < 32'd6) begin
                        n_ec = ERR_HLEN;
                        n_ph = PH_DONE;
                    end else begin
                        n_sk = n_hl - 32'd6;
                        if (n_sk != 32'd0) n_ph = PH_HSKIP;
                        else ah = 1'b1;
                    end
                end
            end
        end else if (n_ph == PH_HSKIP) begin
            n_sk = n_sk - 32'd1;
            if (n_sk == 32'd0) ah = 1'b1;
        end else if (n_ph == PH_CHUNK_ID || n_ph == PH_CHUNK_LEN) begin
            // chunk header
            idx   = n_fbc;
            n_fbc = n_fbc + 4'd1;
            if (idx < 4'd4) begin
                if (i_byte != trk_magic(idx[1:0])) n_bad = 1'b1;
                if (idx == 4'd3) n_ph = PH_CHUNK_LEN;
            end else begin
                n_cbl = {n_cbl[23:0], i_byte};
                if (idx == 4'd7) begin
                    if (n_bad) begin
                        n_ec = ERR_TRACK;
                        n_ph = PH_DONE;
                    end else begin
                        n_ct = '0; n_rs = '0;
                        n_ph = PH_DELTA; n_vv = '0; n_vl = '0;
                        if (n_cbl == 32'd0) ft = 1'b1;
                    end
                end
            end
        end else if (n_ph != PH_DONE) begin
            // track body byte
            n_cbl = n_cbl - 32'd1;
            if (n_ph == PH_STATUS) begin
                if (i_byte[7]) begin
                    n_rs = i_byte;
                    body = 1'b0;
                end
                if (n_rs == ST_META) begin
                    n_ph = PH_META_TYPE;
                end else if (n_rs == ST_SYSEX || n_rs == ST_SYSEX_CONT) begin
                    n_ph = PH_SYSEX_LEN; n_vv = '0; n_vl = '0;
                end else begin
                    n_ph = PH_D1;
                end
            end
            if (body) begin
                unique case (n_ph)
                    PH_DELTA: begin
                        n_vv = {n_vv[24:0], i_byte[6:0]};
                        n_vl = n_vl + 3'd1;
                        if (!i_byte[7] || n_vl >= 3'd4) begin
                            n_ct = sat_add(n_ct, n_vv);
                            n_ph = PH_STATUS;
                        end
                    end
                    PH_META_TYPE: begin
                        n_mk = i_byte;
                        n_ph = PH_META_LEN; n_vv = '0; n_vl = '0;
                    end
                    PH_META_LEN, PH_SYSEX_LEN: begin
                        n_vv = {n_vv[24:0], i_byte[6:0]};
                        n_vl = n_vl + 3'd1;
                        if (!i_byte[7] || n_vl >= 3'd4) begin
                            if (n_ph == PH_META_LEN && n_mk == META_TEMPO &&
                                n_vv == 32'd3 && n_cbl >= 32'd3) begin
                                n_tg = '0; n_sk = 32'd3; n_ph = PH_TEMPO;
                            end else if (n_vv == 32'd0) begin
                                n_ph = PH_DELTA; n_vl = '0;
                            end else begin
                                n_sk = n_vv; n_ph = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP: begin
                        n_sk = n_sk - 32'd1;
                        if (n_sk == 32'd0) begin
                            n_ph = PH_DELTA; n_vv = '0; n_vl = '0;
                        end
                    end
                    PH_TEMPO: begin
                        n_tg = {n_tg[15:0], i_byte};
                        n_sk = n_sk - 32'd1;
                        if (n_sk == 32'd0) begin
                            rv = '0;
                            rv.kind = KIND_TEMPO;
                            rv.track = n_ti + 16'd1;
                            rv.tick = n_ct;
                            rv.tempo_us = n_tg;
                            r0 = rv; cnt = 2'd1;
                            if (n_ct == 32'd0) n_st = n_tg;
                            n_ph = PH_DELTA; n_vv = '0; n_vl = '0;
                        end
                    end
                    PH_D1: begin
                        n_fd = i_byte;
                        if (n_rs[7:4] == TYPE_PROG || n_rs[7:4] == TYPE_PRESS) vdo = 1'b1;
                        else n_ph = PH_D2;
                    end
                    PH_D2: begin
                        vdo = 1'b1;
                        vd2 = i_byte;
                    end
                    default: ;
                endcase
            end
            if (n_cbl == 32'd0) ft = 1'b1;
        end

        // channel message finished inside the body
        if (vdo) begin
            if (n_rs[7:4] == TYPE_ON || n_rs[7:4] == TYPE_OFF) begin
                rv = '0;
                rv.kind = (n_rs[7:4] == TYPE_ON && vd2 != 8'd0) ? KIND_ON : KIND_OFF;
                if (rv.kind == KIND_ON && n_ns != SAT_MAX) n_ns = n_ns + 32'd1;
                rv.track = n_ti + 16'd1;
                rv.tick = n_ct;
                rv.channel = n_rs[3:0];
                rv.key = n_fd;
                rv.velocity = vd2;
                r0 = rv; cnt = 2'd1;
            end
            n_ph = PH_DELTA; n_vv = '0; n_vl = '0;
        end

        if (ah) begin
            n_fbc = '0; n_cbl = '0; n_bad = 1'b0;
            n_ph = (n_td == 16'd0) ? PH_DONE : PH_CHUNK_ID;
        end

        // end of file: short header check and forced track end
        if (i_eof) begin
            if (n_ph <= PH_HWORDS && n_ec == ERR_NONE) n_ec = ERR_MAGIC;
            if (n_ph >= PH_DELTA && n_ph <= PH_D2) ft = 1'b1;
        end

        // track end: flush a partial delta or a cut message
        if (ft) begin
            vdo = 1'b0;
            if (n_ph == PH_DELTA && n_vl != 3'd0) begin
                n_ct = sat_add(n_ct, n_vv);
            end else if (n_ph == PH_D1) begin
                n_fd = '0; vdo = 1'b1;
            end else if (n_ph == PH_D2) begin
                vdo = 1'b1;
            end
            if (vdo && (n_rs[7:4] == TYPE_ON || n_rs[7:4] == TYPE_OFF)) begin
                rv = '0;
                rv.kind = KIND_OFF;
                rv.track = n_ti + 16'd1;
                rv.tick = n_ct;
                rv.channel = n_rs[3:0];
                rv.key = n_fd;
                if (cnt == 2'd0) begin
                    r0 = rv; cnt = 2'd1;
                end else begin
                    r1 = rv; cnt = 2'd2;
                end
            end
            if (n_ct > n_lt) n_lt = n_ct;
            n_ti = n_ti + 16'd1;
            n_fbc = '0; n_cbl = '0; n_bad = 1'b0;
            n_ph = (n_ti >= n_td) ? PH_DONE : PH_CHUNK_ID;
        end

        // summary and return to reset state
        if (i_eof) begin
            rv = '0;
            rv.kind = KIND_SUMMARY;
            rv.tick = n_lt;
            rv.tempo_us = n_st;
            rv.note_count = n_ns;
            rv.file_format = n_fw;
            rv.ticks_per_quarter = n_dv[14:0];
            rv.error = n_ec;
            rv.last_result = 1'b1;
            if (cnt == 2'd0) begin
                r0 = rv; cnt = 2'd1;
            end else begin
                r1 = rv; cnt = 2'd2;
            end
            pdone = 1'b1;
        end

        if (pdone) begin
            n_ph = PH_MAGIC; n_fbc = '0; n_hl = '0; n_td = '0; n_ti = '0;
            n_cbl = '0; n_vv = '0; n_vl = '0; n_ct = '0; n_rs = '0;
            n_mk = '0; n_sk = '0; n_fd = '0; n_tg = '0; n_ns = '0;
            n_lt = '0; n_st = TEMPO_DEFAULT; n_dv = DIV_DEFAULT; n_fw = '0;
            n_ec = ERR_NONE; n_bad = 1'b0;
        end

        o_cnt  = i_acc ? cnt : 2'd0;
        o_res0 = r0;
        o_res1 = r1;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_MAGIC; r_fbc <= '0; r_hl <= '0; r_td <= '0; r_ti <= '0;
            r_cbl <= '0; r_vv <= '0; r_vl <= '0; r_ct <= '0; r_rs <= '0;
            r_mk <= '0; r_sk <= '0; r_fd <= '0; r_tg <= '0; r_ns <= '0;
            r_lt <= '0; r_st <= TEMPO_DEFAULT; r_dv <= DIV_DEFAULT; r_fw <= '0;
            r_ec <= ERR_NONE; r_bad <= 1'b0;
        end else if (i_acc) begin
            r_ph <= n_ph; r_fbc <= n_fbc; r_hl <= n_hl; r_td <= n_td; r_ti <= n_ti;
            r_cbl <= n_cbl; r_vv <= n_vv; r_vl <= n_vl; r_ct <= n_ct; r_rs <= n_rs;
            r_mk <= n_mk; r_sk <= n_sk; r_fd <= n_fd; r_tg <= n_tg; r_ns <= n_ns;
            r_lt <= n_lt; r_st <= n_st; r_dv <= n_dv; r_fw <= n_fw;
            r_ec <= n_ec; r_bad <= n_bad;
        end
    end

`ifndef ASSERT_OFF
    a_eof_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_eof) |-> (o_cnt != 2'd0))
        else $error("end of file without summary");
    a_two_only_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cnt == 2'd2) |-> i_eof)
        else $error("two results without end of file");
    a_eof_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_eof) |=> (r_ph == PH_MAGIC && r_fbc == 4'd0))
        else $error("parser not back at header after end of file");
`endif

endmodule

[design/smf_rq.sv]
// ============================================================================
// smf_rq
// Result queue: takes up to two results per cycle, hands out one.
// ============================================================================
module smf_rq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_cnt,
    input  smf_pkg::t_result    i_res0,
    input  smf_pkg::t_result    i_res1,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output smf_pkg::t_result    o_res
);
    import smf_pkg::*;

    t_result          r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp, r_rp;
    logic [RQ_AW:0]   r_cnt;
    logic             pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];
    assign o_room  = (r_cnt <= (RQ_AW + 1)'(RQ_DEPTH - 2));

    // storage
    always_ff @(posedge i_clk) begin
        if (i_cnt != 2'd0) r_mem[r_wp] <= i_res0;
        if (i_cnt == 2'd2) r_mem[r_wp + RQ_AW'(1)] <= i_res1;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + RQ_AW'(i_cnt);
            r_rp  <= r_rp + RQ_AW'(pop);
            r_cnt <= r_cnt + (RQ_AW + 1)'(i_cnt) - (RQ_AW + 1)'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (RQ_AW + 1)'(RQ_DEPTH))
        else $error("result queue overflow");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cnt != 2'd0) |-> o_room)
        else $error("push without room");
    a_pop_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_cnt == 2'd0) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("fill count wrong after pop");
`endif

endmodule

[design/midi_file_event_parser.sv]
// ============================================================================
// midi_file_event_parser
// Streaming Standard MIDI File parser with note, tempo and summary results.
// ============================================================================
// Takes one file byte per cycle (one item per clock when the result side keeps
// up); each byte updates the parser state in a single pass and its results go
// into a four-entry result queue, so input is held off only while the queue
// has fewer than two free entries. A byte yields up to two results: a note or
// tempo event, and on the byte marked end of file a summary, after which the
// parser is back at its reset state for the next file.
module midi_file_event_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_track,
    output logic [31:0] o_tick,
    output logic [3:0]  o_channel,
    output logic [7:0]  o_key,
    output logic [7:0]  o_velocity,
    output logic [23:0] o_tempo_us,
    output logic [31:0] o_note_count,
    output logic [15:0] o_file_format,
    output logic [14:0] o_ticks_per_quarter,
    output logic [1:0]  o_error,
    output logic        o_last_result
);
    import smf_pkg::*;

    logic       acc;
    logic [1:0] cnt;
    t_result    res0, res1, head;

    assign acc = i_in_valid && o_in_ready;

    // byte parser
    smf_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_byte  (i_file_byte),
        .i_eof   (i_end_of_file),
        .o_cnt   (cnt),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    // result queue
    smf_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cnt   (cnt),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room  (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (head)
    );

    assign o_kind              = head.kind;
    assign o_track             = head.track;
    assign o_tick              = head.tick;
    assign o_channel           = head.channel;
    assign o_key               = head.key;
    assign o_velocity          = head.velocity;
    assign o_tempo_us          = head.tempo_us;
    assign o_note_count        = head.note_count;
    assign o_file_format       = head.file_format;
    assign o_ticks_per_quarter = head.ticks_per_quarter;
    assign o_error             = head.error;
    assign o_last_result       = head.last_result;

endmodule

[tb/tb.sv]
// ============================================================================
// tb
// Checks the MIDI file parser against its own byte-level model of the parser,
// with directed files, random well-formed and broken files, and random gaps.
// ============================================================================
`timescale 1ns / 100ps

module tb;
    import smf_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_file_byte;
    logic        i_end_of_file;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [15:0] o_track;
    logic [31:0] o_tick;
    logic [3:0]  o_channel;
    logic [7:0]  o_key;
    logic [7:0]  o_velocity;
    logic [23:0] o_tempo_us;
    logic [31:0] o_note_count;
    logic [15:0] o_file_format;
    logic [14:0] o_ticks_per_quarter;
    logic [1:0]  o_error;
    logic        o_last_result;

    midi_file_event_parser u_top (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // parser model state
    logic [3:0]  m_phase;
    logic [31:0] m_fcount, m_hlen, m_chunk_left, m_vlq, m_tick, m_skip;
    logic [31:0] m_notes, m_max_tick;
    logic [2:0]  m_vlq_len;
    logic [7:0]  m_status, m_meta, m_d1;
    logic [23:0] m_tempo_acc, m_start_tempo;
    logic [15:0] m_ntracks, m_track, m_division, m_format;
    logic [1:0]  m_err;
    logic        m_id_bad;

    t_result     expected_results[$];
    int          fail_count;
    bit          stall_enable;

    // append one expected result
    task automatic exp_add(input t_result r);
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic logic [7:0] hdr_byte(input int idx);
        case (idx)
            0: return 8'h4D;
            1: return 8'h54;
            2: return 8'h68;
            default: return 8'h64;
        endcase
    endfunction

    function automatic logic [7:0] trk_byte(input int idx);
        case (idx)
            0: return 8'h4D;
            1: return 8'h54;
            2: return 8'h72;
            default: return 8'h6B;
        endcase
    endfunction

    task automatic model_reset();
        m_phase = PH_MAGIC;
        m_fcount = 0; m_hlen = 0; m_chunk_left = 0; m_vlq = 0; m_tick = 0;
        m_skip = 0; m_notes = 0; m_max_tick = 0; m_vlq_len = 0;
        m_status = 0; m_meta = 0; m_d1 = 0; m_tempo_acc = 0;
        m_start_tempo = TEMPO_DEFAULT; m_division = DIV_DEFAULT;
        m_ntracks = 0; m_track = 0; m_format = 0; m_err = ERR_NONE;
        m_id_bad = 1'b0;
    endtask

    task automatic push_event(input logic [1:0] kind, input logic [3:0] ch,
                              input logic [7:0] key, input logic [7:0] vel,
                              input logic [23:0] tempo);
        t_result r;
        r = '0;
        r.kind = kind;
        r.track = m_track + 16'd1;
        r.tick = m_tick;
        r.channel = ch;
        r.key = key;
        r.velocity = vel;
        r.tempo_us = tempo;
        exp_add(r);
    endtask

    task automatic add_delta(input logic [31:0] v);
        m_tick = sat_add(m_tick, v);
    endtask

    task automatic vlq_begin(input logic [3:0] ph);
        m_phase = ph;
        m_vlq = 0;
        m_vlq_len = 0;
    endtask

    function automatic bit vlq_take(input logic [7:0] b);
        m_vlq = (m_vlq << 7) | {25'd0, b[6:0]};
        m_vlq_len++;
        return !b[7] || m_vlq_len >= 4;
    endfunction

    task automatic voice_done(input logic [7:0] d2);
        logic [3:0] typ;
        logic       on;
        typ = m_status[7:4];
        if (typ == TYPE_ON || typ == TYPE_OFF) begin
            on = (typ == TYPE_ON && d2 != 0);
            if (on && m_notes != SAT_MAX) m_notes++;
            push_event(on ? KIND_ON : KIND_OFF, m_status[3:0], m_d1, d2, 24'd0);
        end
        vlq_begin(PH_DELTA);
    endtask

    task automatic track_done();
        if (m_phase == PH_DELTA && m_vlq_len > 0) add_delta(m_vlq);
        else if (m_phase == PH_D1) begin
            m_d1 = 0;
            voice_done(8'd0);
        end else if (m_phase == PH_D2) voice_done(8'd0);
        if (m_tick > m_max_tick) m_max_tick = m_tick;
        m_track++;
        m_fcount = 0;
        m_chunk_left = 0;
        m_id_bad = 1'b0;
        m_phase = (m_track >= m_ntracks) ? PH_DONE : PH_CHUNK_ID;
    endtask

    task automatic header_done();
        m_fcount = 0;
        m_chunk_left = 0;
        m_id_bad = 1'b0;
        m_phase = (m_ntracks == 0) ? PH_DONE : PH_CHUNK_ID;
    endtask

    task automatic body_begin();
        if (m_status == ST_META) m_phase = PH_META_TYPE;
        else if (m_status == ST_SYSEX || m_status == ST_SYSEX_CONT) vlq_begin(PH_SYSEX_LEN);
        else m_phase = PH_D1;
    endtask

    task automatic track_step(input logic [7:0] b);
        if (m_phase == PH_STATUS) begin
            if (b[7]) begin
                m_status = b;
                body_begin();
                return;
            end
            body_begin();
        end
        case (m_phase)
            PH_DELTA: begin
                if (vlq_take(b)) begin
                    add_delta(m_vlq);
                    m_phase = PH_STATUS;
                end
            end
            PH_META_TYPE: begin
                m_meta = b;
                vlq_begin(PH_META_LEN);
            end
            PH_META_LEN, PH_SYSEX_LEN: begin
                if (vlq_take(b)) begin
                    if (m_phase == PH_META_LEN && m_meta == META_TEMPO && m_vlq == 3
                        && m_chunk_left >= 3) begin
                        m_tempo_acc = 0;
                        m_skip = 3;
                        m_phase = PH_TEMPO;
                    end else if (m_vlq == 0) vlq_begin(PH_DELTA);
                    else begin
                        m_skip = m_vlq;
                        m_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                m_skip--;
                if (m_skip == 0) vlq_begin(PH_DELTA);
            end
            PH_TEMPO: begin
                m_tempo_acc = {m_tempo_acc[15:0], b};
                m_skip--;
                if (m_skip == 0) begin
                    push_event(KIND_TEMPO, 4'd0, 8'd0, 8'd0, m_tempo_acc);
                    if (m_tick == 0) m_start_tempo = m_tempo_acc;
                    vlq_begin(PH_DELTA);
                end
            end
            PH_D1: begin
                m_d1 = b;
                if (m_status[7:4] == TYPE_PROG || m_status[7:4] == TYPE_PRESS)
                    voice_done(8'd0);
                else m_phase = PH_D2;
            end
            PH_D2: voice_done(b);
            default: ;
        endcase
    endtask

    task automatic header_step(input logic [7:0] b);
        logic [31:0] i;
        i = m_fcount;
        m_fcount++;
        if (m_phase == PH_MAGIC) begin
            if (b != hdr_byte(i[1:0])) begin
                m_err = ERR_MAGIC;
                m_phase = PH_DONE;
                return;
            end
            if (i == 3) m_phase = PH_HLEN;
        end else if (m_phase == PH_HLEN) begin
            m_hlen = (m_hlen << 8) | b;
            if (i == 7) m_phase = PH_HWORDS;
        end else begin
            if (i < 10) m_format = {m_format[7:0], b};
            else if (i < 12) m_ntracks = {m_ntracks[7:0], b};
            else if (i == 12) m_division = {b, 8'd0};
            else begin
                m_division = m_division | b;
                if (m_division == 0 || m_division[15]) m_division = DIV_DEFAULT;
                if (m_hlen < 6) begin
                    m_err = ERR_HLEN;
                    m_phase = PH_DONE;
                    return;
                end
                m_skip = m_hlen - 6;
                if (m_skip > 0) m_phase = PH_HSKIP;
                else header_done();
            end
        end
    endtask

    // one accepted byte through the model
    task automatic predict_byte(input logic [7:0] b, input logic eof);
        logic [31:0] i;
        t_result     s;
        if (m_phase <= PH_HWORDS) header_step(b);
        else if (m_phase == PH_HSKIP) begin
            m_skip--;
            if (m_skip == 0) header_done();
        end else if (m_phase == PH_CHUNK_ID || m_phase == PH_CHUNK_LEN) begin
            i = m_fcount;
            m_fcount++;
            if (i < 4) begin
                if (b != trk_byte(i[1:0])) m_id_bad = 1'b1;
                if (i == 3) m_phase = PH_CHUNK_LEN;
            end else begin
                m_chunk_left = (m_chunk_left << 8) | b;
                if (i == 7) begin
                    if (m_id_bad) begin
                        m_err = ERR_TRACK;
                        m_phase = PH_DONE;
                    end else begin
                        m_tick = 0;
                        m_status = 0;
                        vlq_begin(PH_DELTA);
                        if (m_chunk_left == 0) track_done();
                    end
                end
            end
        end else if (m_phase != PH_DONE) begin
            m_chunk_left--;
            track_step(b);
            if (m_chunk_left == 0) track_done();
        end
        if (eof) begin
            if (m_phase <= PH_HWORDS && m_err == ERR_NONE) m_err = ERR_MAGIC;
            if (m_phase >= PH_DELTA && m_phase <= PH_D2) track_done();
            s = '0;
            s.kind = KIND_SUMMARY;
            s.tick = m_max_tick;
            s.tempo_us = m_start_tempo;
            s.note_count = m_notes;
            s.file_format = m_format;
            s.ticks_per_quarter = m_division[14:0];
            s.error = m_err;
            s.last_result = 1'b1;
            exp_add(s);
            model_reset();
        end
    endtask

    // send one byte; predict on acceptance; valid stays up for the next item
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        if (stall_enable && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 18);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_file_byte <= b;
        i_end_of_file <= eof;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_byte(b, eof);
        @(negedge i_clk);
    endtask

    // file building
    logic [7:0] fbuf[$];

    task automatic fb_add(input logic [7:0] v);
        fbuf.insert(fbuf.size(), v);
    endtask

    task automatic put16(input logic [15:0] v);
        fb_add(v[15:8]);
        fb_add(v[7:0]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[31:16]);
        put16(v[15:0]);
    endtask

    task automatic put_header(input logic [15:0] fmt, input logic [15:0] ntrk,
                              input logic [15:0] div);
        for (int k = 0; k < 4; k++) fb_add(hdr_byte(k));
        put32(32'd6);
        put16(fmt);
        put16(ntrk);
        put16(div);
    endtask

    task automatic put_track(input logic [7:0] body[$]);
        for (int k = 0; k < 4; k++) fb_add(trk_byte(k));
        put32(32'(body.size()));
        foreach (body[k]) fb_add(body[k]);
    endtask

    task automatic send_file();
        foreach (fbuf[k]) send_byte(fbuf[k], k == fbuf.size() - 1);
        fbuf.delete();
    endtask

    // random track body, mostly well-formed events
    task automatic rand_body(output logic [7:0] body[$], input int events);
        int n;
        body.delete();
        for (int e = 0; e < events; e++) begin
            n = $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0) n = 3;
            for (int k = n; k > 0; k--) body.insert(body.size(), {1'b1, 7'($urandom)});
            body.insert(body.size(), {1'b0, 7'($urandom)});
            case ($urandom_range(0, 9))
                0: begin
                    body.insert(body.size(), ST_META);
                    body.insert(body.size(), META_TEMPO);
                    body.insert(body.size(), 8'd3);
                    repeat (3) body.insert(body.size(), 8'($urandom));
                end
                1: begin
                    body.insert(body.size(), $urandom_range(0, 1) ? ST_SYSEX : ST_META);
                    if (body[$] == ST_META) body.insert(body.size(), 8'($urandom));
                    n = $urandom_range(0, 4);
                    body.insert(body.size(), 8'(n));
                    repeat (n) body.insert(body.size(), 8'($urandom));
                end
                2: begin
                    body.insert(body.size(), {$urandom_range(0, 1) ? TYPE_PROG : TYPE_PRESS,
                                              4'($urandom)});
                    body.insert(body.size(), 8'($urandom));
                end
                3: begin
                    // running status data
                    body.insert(body.size(), 8'($urandom_range(0, 127)));
                    body.insert(body.size(), 8'($urandom));
                end
                4: body.insert(body.size(), 8'($urandom));
                default: begin
                    body.insert(body.size(), {$urandom_range(0, 1) ? TYPE_ON : TYPE_OFF,
                                              4'($urandom)});
                    body.insert(body.size(), 8'($urandom));
                    body.insert(body.size(),
                                $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom));
                end
            endcase
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result kind %0d", o_kind);
                fail_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_kind !== e.kind) begin
                    $error("kind exp %0h got %0h", e.kind, o_kind); fail_count++;
                end
                if (o_track !== e.track) begin
                    $error("track exp %0h got %0h", e.track, o_track); fail_count++;
                end
                if (o_tick !== e.tick) begin
                    $error("tick exp %0h got %0h", e.tick, o_tick); fail_count++;
                end
                if (o_channel !== e.channel) begin
                    $error("channel exp %0h got %0h", e.channel, o_channel); fail_count++;
                end
                if (o_key !== e.key) begin
                    $error("key exp %0h got %0h", e.key, o_key); fail_count++;
                end
                if (o_velocity !== e.velocity) begin
                    $error("velocity exp %0h got %0h", e.velocity, o_velocity); fail_count++;
                end
                if (o_tempo_us !== e.tempo_us) begin
                    $error("tempo_us exp %0h got %0h", e.tempo_us, o_tempo_us); fail_count++;
                end
                if (o_note_count !== e.note_count) begin
                    $error("note_count exp %0h got %0h", e.note_count, o_note_count);
                    fail_count++;
                end
                if (o_file_format !== e.file_format) begin
                    $error("file_format exp %0h got %0h", e.file_format, o_file_format);
                    fail_count++;
                end
                if (o_ticks_per_quarter !== e.ticks_per_quarter) begin
                    $error("ticks_per_quarter exp %0h got %0h", e.ticks_per_quarter,
                           o_ticks_per_quarter);
                    fail_count++;
                end
                if (o_error !== e.error) begin
                    $error("error exp %0h got %0h", e.error, o_error); fail_count++;
                end
                if (o_last_result !== e.last_result) begin
                    $error("last_result exp %0h got %0h", e.last_result, o_last_result);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls in bursts
    int stall_left;
    always @(negedge i_clk) begin
        if (!stall_enable) i_out_ready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 17);
            i_out_ready <= 1'b0;
        end else i_out_ready <= 1'b1;
    end

    // run limit
    int cycle_count;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_basic_file();
        logic [7:0] body[$];
        put_header(16'd1, 16'd2, 16'd96);
        body = '{8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20,
                 8'h00, 8'h90, 8'h3C, 8'h7F, 8'h81, 8'h00, 8'h3C, 8'h00,
                 8'h10, 8'h8F, 8'hFF, 8'hFF, 8'h00, 8'hC3, 8'h05,
                 8'h00, 8'hF0, 8'h02, 8'h11, 8'hF7, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h9A,
                 8'h40};
        put_track(body);
        body = '{8'h00, 8'h3C, 8'h40, 8'h00, 8'hD2, 8'h10, 8'h00, 8'hFF, 8'h2F, 8'h00};
        put_track(body);
        send_file();
    endtask

    task automatic test_header_cases();
        // bad magic
        fbuf = '{8'h4D, 8'h00, 8'h00};
        send_file();
        // short file
        fbuf = '{8'h4D, 8'h54};
        send_file();
        fbuf = '{8'hFF};
        send_file();
        // header length under 6
        for (int k = 0; k < 4; k++) fb_add(hdr_byte(k));
        put32(32'd5); put16(16'hFFFF); put16(16'd1); put16(16'd0);
        send_file();
        // extra header bytes, zero tracks, SMPTE division
        for (int k = 0; k < 4; k++) fb_add(hdr_byte(k));
        put32(32'd8); put16(16'd0); put16(16'd0); put16(16'hE728);
        put16(16'hABCD); fb_add(8'h55);
        send_file();
        // zero division, then bad track id
        put_header(16'd0, 16'd1, 16'd0);
        fb_add(8'h4D); fb_add(8'h54); fb_add(8'h72);
        fb_add(8'h00); put32(32'd0); fb_add(8'h90);
        send_file();
    endtask

    task automatic test_truncation();
        logic [7:0] body[$];
        // note cut by file end, delta cut by chunk end, overlong meta
        put_header(16'd1, 16'd3, 16'h7FFF);
        body = '{8'h00, 8'hFF, 8'h01, 8'h7F, 8'h41};
        put_track(body);
        body = '{8'h00, 8'h9F, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        put_track(body);
        put32(32'h4D54726B); put32(32'd20); fb_add(8'h00);
        fb_add(8'h93); fb_add(8'h30);
        send_file();
        // tempo that runs past the chunk, chunk header cut by file end
        put_header(16'd1, 16'd2, 16'd1);
        body = '{8'h00, 8'hFF, 8'h51, 8'h03, 8'h01};
        put_track(body);
        put32(32'h4D54726B); fb_add(8'h00);
        send_file();
    endtask

    task automatic test_random_files(input int target);
        logic [7:0] body[$];
        int         ntrk, sent;
        sent = 0;
        while (sent < target) begin
            ntrk = $urandom_range(1, 3);
            put_header(16'($urandom_range(0, 2)), 16'(ntrk),
                       $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(1, 960)));
            for (int t = 0; t < ntrk; t++) begin
                rand_body(body, $urandom_range(1, 8));
                if ($urandom_range(0, 9) == 0) begin
                    // broken chunk: length off or bad id
                    fb_add(trk_byte(0));
                    fb_add(8'($urandom));
                    fb_add(trk_byte(2));
                    fb_add(trk_byte(3));
                    put32(32'(body.size()));
                    foreach (body[k]) fb_add(body[k]);
                end else if ($urandom_range(0, 9) == 0) begin
                    for (int k = 0; k < 4; k++) fb_add(trk_byte(k));
                    put32(32'($urandom_range(0, body.size() + 4)));
                    foreach (body[k]) fb_add(body[k]);
                end else put_track(body);
            end
            // occasional trailing noise or truncation
            if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4))
                fb_add(8'($urandom));
            if ($urandom_range(0, 7) == 0)
                fbuf = fbuf[0:$urandom_range(0, fbuf.size() - 1)];
            sent += fbuf.size();
            send_file();
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    initial begin
        fail_count = 0;
        cycle_count = 0;
        stall_left = 0;
        stall_enable = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_file_byte = '0;
        i_end_of_file = 1'b0;
        model_reset();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_file();
        test_header_cases();
        test_truncation();
        // sender holds off until the result side is empty
        drain();
        stall_enable = 1'b1;
        test_random_files(550);
        stall_enable = 1'b0;
        test_random_files(200);
        drain();

        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
design/smf_pkg.sv
design/smf_core.sv
design/smf_rq.sv
design/midi_file_event_parser.sv
tb/tb.sv
